// File: hdl/rde_pkg.sv
package rde_pkg;

    localparam int CFG_W       = 5;
    localparam int ENTRY_IDX_W = 4;
    localparam int CODE_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h00;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  length;
    } dict_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT,
        ST_NEWRUN,
        ST_ENDFL
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_OLD,
        PH_LONG,
        PH_END
    } phase_t;

    typedef struct packed {
        logic load;
        logic capture;
        logic start_old;
        logic start_long;
        logic start_end;
        logic bump;
        logic new_run;
        logic clear_run;
        logic scan_clr;
        logic scan;
        logic emit;
        logic emit_last;
        logic consume;
        logic set_cnt_rem;
    } dp_cmd_t;

    typedef struct packed {
        logic same_run;
        logic run_full;
        logic has_run;
        logic end_item;
        logic hit;
        logic miss;
        logic out_free;
        logic rem_zero;
    } dp_sts_t;

endpackage

// File: hdl/rde_ctrl.sv
module rde_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  rde_pkg::dp_sts_t  sts,
    output rde_pkg::dp_cmd_t  cmd
);
    import rde_pkg::*;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_OLD;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == CMD_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (sts.same_run) begin
                    if (sts.run_full) begin
                        // A full run gives up one token from its front first.
                        cmd.start_long = 1'b1;
                        cmd.scan_clr   = 1'b1;
                        phase_next     = PH_LONG;
                        state_next     = ST_SCAN;
                    end else begin
                        cmd.bump   = 1'b1;
                        state_next = sts.end_item ? ST_ENDFL : ST_IDLE;
                    end
                end else if (sts.has_run) begin
                    cmd.start_old = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    phase_next    = PH_OLD;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_NEWRUN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.miss) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    unique case (phase_reg)
                        PH_LONG: begin
                            cmd.emit_last   = !sts.end_item;
                            cmd.set_cnt_rem = 1'b1;
                            state_next      = sts.end_item ? ST_ENDFL : ST_IDLE;
                        end
                        PH_OLD: begin
                            // The new run still has to be flushed when the word ends the chunk.
                            cmd.emit_last = sts.rem_zero && !sts.end_item;
                            cmd.consume   = 1'b1;
                            if (sts.rem_zero) begin
                                state_next = ST_NEWRUN;
                            end else begin
                                cmd.scan_clr = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        PH_END: begin
                            cmd.emit_last = sts.rem_zero;
                            cmd.consume   = 1'b1;
                            if (sts.rem_zero) begin
                                cmd.clear_run = 1'b1;
                                state_next    = ST_IDLE;
                            end else begin
                                cmd.scan_clr = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NEWRUN: begin
                cmd.new_run = 1'b1;
                state_next  = sts.end_item ? ST_ENDFL : ST_IDLE;
            end
            ST_ENDFL: begin
                cmd.start_end = 1'b1;
                cmd.scan_clr  = 1'b1;
                phase_next    = PH_END;
                state_next    = ST_SCAN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rde_datapath.sv
module rde_datapath #(
    parameter int DICT_ENTRIES    = 16,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [rde_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [rde_pkg::ENTRY_IDX_W-1:0] s_entry_index,
    input  logic [rde_pkg::CODE_W-1:0]   s_entry_code,
    input  logic [rde_pkg::BYTE_W-1:0]   s_entry_value,
    input  logic [rde_pkg::LEN_W-1:0]    s_entry_length,
    input  logic [rde_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                         s_chunk_end,
    input  rde_pkg::dp_cmd_t             cmd,
    output rde_pkg::dp_sts_t             sts,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [rde_pkg::BYTE_W-1:0]   m_first_byte,
    output logic [rde_pkg::BYTE_W-1:0]   m_second_byte,
    output logic                         m_two_bytes,
    output logic                         m_last_of_run,
    output logic                         m_stream_done
);
    import rde_pkg::*;

    localparam int AW    = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int IW    = $clog2(DICT_ENTRIES + 1);
    localparam int NW    = (IW > CFG_W) ? IW : CFG_W;
    localparam int SW    = (IW > ENTRY_IDX_W) ? IW : ENTRY_IDX_W;
    localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 2);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    dict_entry_t mem [DICT_ENTRIES];

    logic [CFG_W-1:0]  eiu_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;
    logic [BYTE_W-1:0] run_value_reg;
    logic [CNT_W-1:0]  run_count_reg;
    logic              run_active_reg;
    logic [CNT_W-1:0]  avail_reg;
    logic [IW-1:0]     idx_reg;
    logic              rd_vld_reg;
    dict_entry_t       rd_reg;
    logic              found_reg;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] second_reg;
    logic              two_reg;
    logic              last_reg;
    logic              done_reg;

    logic [NW-1:0]     n_lim;
    logic              idx_done;
    logic              hit;
    logic              miss;
    logic [CMP_W-1:0]  used;
    logic [CMP_W-1:0]  rem;
    logic [BYTE_W-1:0] tok_first;
    logic [BYTE_W-1:0] tok_second;
    logic              tok_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eiu_reg <= '0;
        end else if (cfg_wr_en) begin
            eiu_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && (SW'(s_entry_index) < SW'(DICT_ENTRIES))) begin
            mem[AW'(s_entry_index)] <= '{code: s_entry_code, value: s_entry_value,
                                        length: s_entry_length};
        end
    end

    // Slots are searched in order, one read a cycle; a hit freezes the read data.
    assign n_lim    = (NW'(eiu_reg) > NW'(DICT_ENTRIES)) ? NW'(DICT_ENTRIES) : NW'(eiu_reg);
    assign idx_done = NW'(idx_reg) >= n_lim;
    assign hit      = rd_vld_reg
                      && (rd_reg.length != '0)
                      && (CMP_W'(rd_reg.length) <= CMP_W'(MAX_PATTERN_LEN))
                      && (rd_reg.value == run_value_reg)
                      && (CMP_W'(rd_reg.length) <= CMP_W'(avail_reg));
    assign miss     = !hit && idx_done;

    always_ff @(posedge aclk) begin
        if (cmd.scan && !hit && !idx_done) begin
            rd_reg <= mem[AW'(idx_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else if (cmd.scan && !hit) begin
            if (!idx_done) begin
                idx_reg    <= idx_reg + 1'b1;
                rd_vld_reg <= 1'b1;
            end else begin
                rd_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan && (hit || miss)) begin
            found_reg <= hit;
        end
    end

    assign used = found_reg ? CMP_W'(rd_reg.length) : CMP_W'(1);
    assign rem  = CMP_W'(avail_reg) - used;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg <= s_data_byte;
            end_reg  <= s_chunk_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg  <= '0;
            run_count_reg  <= '0;
            run_active_reg <= 1'b0;
        end else if (cmd.new_run) begin
            run_value_reg  <= byte_reg;
            run_count_reg  <= CNT_W'(1);
            run_active_reg <= 1'b1;
        end else if (cmd.clear_run) begin
            run_count_reg  <= '0;
            run_active_reg <= 1'b0;
        end else if (cmd.bump) begin
            run_count_reg <= run_count_reg + 1'b1;
        end else if (cmd.set_cnt_rem) begin
            run_count_reg <= CNT_W'(rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_old || cmd.start_end) begin
            avail_reg <= run_count_reg;
        end else if (cmd.start_long) begin
            avail_reg <= run_count_reg + 1'b1;
        end else if (cmd.consume) begin
            avail_reg <= CNT_W'(rem);
        end
    end

    always_comb begin
        if (found_reg) begin
            tok_first  = MARKER_BYTE;
            tok_second = rd_reg.code;
            tok_two    = 1'b1;
        end else if (run_value_reg == MARKER_BYTE) begin
            tok_first  = MARKER_BYTE;
            tok_second = ESCAPE_BYTE;
            tok_two    = 1'b1;
        end else begin
            tok_first  = run_value_reg;
            tok_second = '0;
            tok_two    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            first_reg  <= tok_first;
            second_reg <= tok_second;
            two_reg    <= tok_two;
            last_reg   <= cmd.emit_last;
            done_reg   <= cmd.emit_last && end_reg;
        end
    end

    assign sts.same_run = run_active_reg && (byte_reg == run_value_reg);
    assign sts.run_full = CMP_W'(run_count_reg) >= CMP_W'(MAX_PATTERN_LEN);
    assign sts.has_run  = run_active_reg && (run_count_reg != '0);
    assign sts.end_item = end_reg;
    assign sts.hit      = hit;
    assign sts.miss     = miss;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.rem_zero = (rem == '0);

    assign m_valid       = m_valid_reg;
    assign m_first_byte  = first_reg;
    assign m_second_byte = second_reg;
    assign m_two_bytes   = two_reg;
    assign m_last_of_run = last_reg;
    assign m_stream_done = done_reg;

endmodule

// File: hdl/run_dictionary_escape_encoder.sv
// A load word is written to its slot when taken; a data word that emits nothing passes
// through ST_DECIDE, and ST_NEWRUN when it starts a run. Each emitted token reads
// dictionary slots one a cycle, at most min(entries_in_use, DICT_ENTRIES) of them, then
// loads the output register once it is free; each word ends before the next is taken.
// Reset (aresetn, synchronous, active low) clears the controller, the pending run, the
// output valid and entries_in_use; dictionary slots keep their contents until loaded.
module run_dictionary_escape_encoder #(
    parameter int DICT_ENTRIES    = 16,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rde_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [rde_pkg::ENTRY_IDX_W-1:0] s_entry_index,
    input  logic [rde_pkg::CODE_W-1:0]      s_entry_code,
    input  logic [rde_pkg::BYTE_W-1:0]      s_entry_value,
    input  logic [rde_pkg::LEN_W-1:0]       s_entry_length,
    input  logic [rde_pkg::BYTE_W-1:0]      s_data_byte,
    input  logic                            s_chunk_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rde_pkg::BYTE_W-1:0]      m_first_byte,
    output logic [rde_pkg::BYTE_W-1:0]      m_second_byte,
    output logic                            m_two_bytes,
    output logic                            m_last_of_run,
    output logic                            m_stream_done
);
    import rde_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .sts     (sts),
        .cmd     (cmd)
    );

    rde_datapath #(
        .DICT_ENTRIES    (DICT_ENTRIES),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_entry_index  (s_entry_index),
        .s_entry_code   (s_entry_code),
        .s_entry_value  (s_entry_value),
        .s_entry_length (s_entry_length),
        .s_data_byte    (s_data_byte),
        .s_chunk_end    (s_chunk_end),
        .cmd            (cmd),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_first_byte   (m_first_byte),
        .m_second_byte  (m_second_byte),
        .m_two_bytes    (m_two_bytes),
        .m_last_of_run  (m_last_of_run),
        .m_stream_done  (m_stream_done)
    );

endmodule
